FILE: rtl/core/udm_pkg.sv
// shared types, constants and control structs of the unsigned division magic unit
package udm_pkg;

    localparam int UDM_WIDTH = 32;
    localparam int DIVISOR_W = 32;
    localparam int MAGIC_W   = 32;
    localparam int SHIFT_W   = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_NC,
        ST_LOAD_Q1,
        ST_DIV_Q1,
        ST_LOAD_Q2,
        ST_DIV_Q2,
        ST_ITER_INIT,
        ST_ITER_STEP,
        ST_ITER_CHECK
    } state_t;

    typedef enum logic [1:0] {
        DVD_NEG_D,
        DVD_TOP,
        DVD_MAXI
    } dividend_t;

    typedef enum logic {
        DVS_D,
        DVS_NC
    } divisor_t;

    typedef struct packed {
        logic      load_d;
        logic      div_load;
        dividend_t dvd_sel;
        divisor_t  dvs_sel;
        logic      div_step;
        logic      cap_nc;
        logic      cap_q1;
        logic      iter_init;
        logic      iter_step;
        logic      emit;
        logic      emit_zero;
    } cmd_t;

    typedef struct packed {
        logic d_zero;
        logic cont;
    } status_t;

endpackage

FILE: rtl/core/udm_datapath.sv
// datapath: divisor store, shared shift-subtract divider and doubling loop registers
module udm_datapath
    import udm_pkg::*;
#(
    parameter int WIDTH = UDM_WIDTH
)
(
    input  logic                 clk,
    input  logic [DIVISOR_W-1:0] divisor,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic [MAGIC_W-1:0]   magic,
    output logic [SHIFT_W-1:0]   post_shift,
    output logic                 add_needed
);

    localparam int PW = $clog2(2 * WIDTH + 1);

    localparam logic [WIDTH-1:0] TOP  = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MAXI = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic [WIDTH-1:0] ONES = {WIDTH{1'b1}};

    logic [WIDTH-1:0]   d_reg, d_next;
    logic [WIDTH-1:0]   nc_reg, nc_next;
    logic [WIDTH-1:0]   rem_reg, rem_next;
    logic [WIDTH-1:0]   dq_reg, dq_next;
    logic [WIDTH-1:0]   q1_reg, q1_next;
    logic [WIDTH-1:0]   r1_reg, r1_next;
    logic [WIDTH-1:0]   q2_reg, q2_next;
    logic [WIDTH-1:0]   r2_reg, r2_next;
    logic [PW-1:0]      p_reg, p_next;
    logic               add_reg, add_next;
    logic [MAGIC_W-1:0] magic_reg, magic_next;
    logic [SHIFT_W-1:0] post_shift_reg, post_shift_next;
    logic               add_out_reg, add_out_next;

    logic [WIDTH+DIVISOR_W-1:0] d_ext;
    logic [WIDTH-1:0]           dvs;
    logic [WIDTH:0]             div_rs;
    logic [WIDTH:0]             div_diff;
    logic                       div_ge;
    logic [WIDTH:0]             r1_dbl, r1_diff;
    logic [WIDTH:0]             r2_dbl, r2_diff;
    logic                       take1, take2;
    logic [WIDTH-1:0]           delta;
    logic [WIDTH-1:0]           magic_w;
    logic [WIDTH+MAGIC_W-1:0]   magic_ext;
    logic [PW-1:0]              ps_full;
    logic [PW+SHIFT_W-1:0]      ps_ext;

    assign d_ext = {{WIDTH{1'b0}}, divisor};

    // one restoring step: shift in the next dividend bit, subtract when it fits
    assign dvs      = (cmd.dvs_sel == DVS_NC) ? nc_reg : d_reg;
    assign div_rs   = {rem_reg, dq_reg[WIDTH-1]};
    assign div_diff = div_rs - {1'b0, dvs};
    assign div_ge   = (div_rs >= {1'b0, dvs});

    // doubling step, comparisons on 2r (2r+1 for q2) against the divisors avoid any wrap
    assign r1_dbl  = {r1_reg, 1'b0};
    assign r1_diff = r1_dbl - {1'b0, nc_reg};
    assign take1   = (r1_dbl >= {1'b0, nc_reg});
    assign r2_dbl  = {r2_reg, 1'b1};
    assign r2_diff = r2_dbl - {1'b0, d_reg};
    assign take2   = (r2_dbl >= {1'b0, d_reg});

    assign delta = d_reg - {{(WIDTH-1){1'b0}}, 1'b1} - r2_reg;

    assign status.d_zero = (d_reg == '0);
    assign status.cont   = (p_reg < PW'(2 * WIDTH))
                        && ((q1_reg < delta) || ((q1_reg == delta) && (r1_reg == '0)));

    assign magic_w   = q2_reg + {{(WIDTH-1){1'b0}}, 1'b1};
    assign magic_ext = {{MAGIC_W{1'b0}}, magic_w};
    assign ps_full   = p_reg - PW'(WIDTH);
    assign ps_ext    = {{SHIFT_W{1'b0}}, ps_full};

    always_comb
    begin
        d_next          = d_reg;
        nc_next         = nc_reg;
        rem_next        = rem_reg;
        dq_next         = dq_reg;
        q1_next         = q1_reg;
        r1_next         = r1_reg;
        q2_next         = q2_reg;
        r2_next         = r2_reg;
        p_next          = p_reg;
        add_next        = add_reg;
        magic_next      = magic_reg;
        post_shift_next = post_shift_reg;
        add_out_next    = add_out_reg;

        if (cmd.load_d)
        begin
            d_next = d_ext[WIDTH-1:0];
        end

        if (cmd.cap_nc)
        begin
            nc_next = ONES - rem_reg;
        end

        if (cmd.cap_q1)
        begin
            q1_next = dq_reg;
            r1_next = rem_reg;
        end

        if (cmd.div_load)
        begin
            rem_next = '0;
            case (cmd.dvd_sel)
                DVD_NEG_D: dq_next = '0 - d_reg;
                DVD_TOP:   dq_next = TOP;
                DVD_MAXI:  dq_next = MAXI;
                default:   dq_next = '0;
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_next = div_ge ? div_diff[WIDTH-1:0] : div_rs[WIDTH-1:0];
            dq_next  = {dq_reg[WIDTH-2:0], div_ge};
        end

        if (cmd.iter_init)
        begin
            q2_next  = dq_reg;
            r2_next  = rem_reg;
            p_next   = PW'(WIDTH - 1);
            add_next = 1'b0;
        end
        else if (cmd.iter_step)
        begin
            p_next  = p_reg + PW'(1);
            q1_next = {q1_reg[WIDTH-2:0], take1};
            r1_next = take1 ? r1_diff[WIDTH-1:0] : r1_dbl[WIDTH-1:0];
            q2_next = {q2_reg[WIDTH-2:0], take2};
            r2_next = take2 ? r2_diff[WIDTH-1:0] : r2_dbl[WIDTH-1:0];
            // sticky: the doubled multiplier no longer fits the word
            if (take2 ? (q2_reg >= MAXI) : (q2_reg >= TOP))
            begin
                add_next = 1'b1;
            end
        end

        if (cmd.emit_zero)
        begin
            magic_next      = '0;
            post_shift_next = '0;
            add_out_next    = 1'b0;
        end
        else if (cmd.emit)
        begin
            magic_next      = magic_ext[MAGIC_W-1:0];
            post_shift_next = ps_ext[SHIFT_W-1:0];
            add_out_next    = add_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg          <= d_next;
        nc_reg         <= nc_next;
        rem_reg        <= rem_next;
        dq_reg         <= dq_next;
        q1_reg         <= q1_next;
        r1_reg         <= r1_next;
        q2_reg         <= q2_next;
        r2_reg         <= r2_next;
        p_reg          <= p_next;
        add_reg        <= add_next;
        magic_reg      <= magic_next;
        post_shift_reg <= post_shift_next;
        add_out_reg    <= add_out_next;
    end

    assign magic      = magic_reg;
    assign post_shift = post_shift_reg;
    assign add_needed = add_out_reg;

endmodule

FILE: rtl/core/udm_ctrl.sv
// controller: sequences the three divisions and the doubling loop
module udm_ctrl
    import udm_pkg::*;
#(
    parameter int WIDTH = UDM_WIDTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    localparam int CW = $clog2(WIDTH);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.dvd_sel = DVD_NEG_D;
        cmd.dvs_sel = DVS_D;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_d = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (status.d_zero)
                begin
                    cmd.emit_zero = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cmd.dvd_sel  = DVD_NEG_D;
                    cnt_next     = CW'(WIDTH - 1);
                    state_next   = ST_DIV_NC;
                end
            end
            ST_DIV_NC:
            begin
                cmd.div_step = 1'b1;
                cmd.dvs_sel  = DVS_D;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_LOAD_Q1;
                end
            end
            ST_LOAD_Q1:
            begin
                // nc lands on the same edge that loads the next dividend
                cmd.cap_nc   = 1'b1;
                cmd.div_load = 1'b1;
                cmd.dvd_sel  = DVD_TOP;
                cnt_next     = CW'(WIDTH - 1);
                state_next   = ST_DIV_Q1;
            end
            ST_DIV_Q1:
            begin
                cmd.div_step = 1'b1;
                cmd.dvs_sel  = DVS_NC;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_LOAD_Q2;
                end
            end
            ST_LOAD_Q2:
            begin
                cmd.cap_q1   = 1'b1;
                cmd.div_load = 1'b1;
                cmd.dvd_sel  = DVD_MAXI;
                cnt_next     = CW'(WIDTH - 1);
                state_next   = ST_DIV_Q2;
            end
            ST_DIV_Q2:
            begin
                cmd.div_step = 1'b1;
                cmd.dvs_sel  = DVS_D;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_ITER_INIT;
                end
            end
            ST_ITER_INIT:
            begin
                cmd.iter_init = 1'b1;
                state_next    = ST_ITER_STEP;
            end
            ST_ITER_STEP:
            begin
                cmd.iter_step = 1'b1;
                state_next    = ST_ITER_CHECK;
            end
            ST_ITER_CHECK:
            begin
                if (status.cont)
                begin
                    state_next = ST_ITER_STEP;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        done_next = cmd.emit | cmd.emit_zero;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: rtl/core/unsigned_division_magic_unit.sv
// top level of the unsigned division magic unit: controller plus datapath
//
// A divisor word is taken when start is high and busy is low; busy then stays
// high until the result word is out. The result (magic, post_shift, add_needed)
// is shown for one cycle with done high and must be taken in that cycle, as the
// receiver cannot stall it; it is the word one would get by the multiply-high
// method for that divisor, and a zero divisor gives an all-zero word. The three
// divisions share one shift-subtract unit at one bit a cycle, and the doubling
// loop runs 1 to WIDTH+1 steps, each with an update state and a test state.
module unsigned_division_magic_unit
    import udm_pkg::*;
#(
    parameter int WIDTH = UDM_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic [MAGIC_W-1:0]   magic,
    output logic [SHIFT_W-1:0]   post_shift,
    output logic                 add_needed
);

    cmd_t    cmd;
    status_t status;

    udm_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    udm_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk        (clk),
        .divisor    (divisor),
        .cmd        (cmd),
        .status     (status),
        .magic      (magic),
        .post_shift (post_shift),
        .add_needed (add_needed)
    );

    // the result word only appears once the sequence has returned to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a zero divisor word gives an all-zero result
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_zero) |=> (done && (magic == '0) && (post_shift == '0) && !add_needed))
        else $error("zero divisor gave a nonzero result");

endmodule
